// ===== rtl/wsms_pkg.sv =====
`default_nettype none

package wsms_pkg;

    localparam int unsigned STEP_LIMIT = 8;
    localparam int unsigned STEP_CNT_W = $clog2(STEP_LIMIT);
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned TIME_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SAFE_HOLD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SELF_RIGHT = 1'd1;

    localparam logic [TIME_W-1:0] SAFE_HOLD_RST  = 32'd1000000;
    localparam logic [TIME_W-1:0] SELF_RIGHT_RST = 32'd2000000;

    typedef enum logic [3:0] {
        MODE_INIT           = 4'd0,
        MODE_SAFE           = 4'd1,
        MODE_UNKNOWN        = 4'd2,
        MODE_NOMINAL        = 4'd3,
        MODE_ARMED          = 4'd4,
        MODE_SWING_TRIG     = 4'd5,
        MODE_RETRACT_TRIG   = 4'd6,
        MODE_ACTIVE         = 4'd7,
        MODE_SELFRIGHT_TRIG = 4'd8,
        MODE_NEEDS_SELFRIGHT = 4'd9
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_STEP = 2'd1,
        ST_OUT  = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic step;
        logic load_out;
    } wsms_cmd_t;

    typedef struct packed {
        logic changed;
        logic out_free;
    } wsms_stat_t;

    typedef struct packed {
        logic radio_ok;
        logic self_right_on;
        logic upright;
        logic upside_down;
        logic hammer_ready;
        logic radio_swing;
        logic autofire_swing;
        logic retract_request;
        logic weapon_enabled;
    } wsms_flags_t;

endpackage

`default_nettype wire

// ===== rtl/wsms_datapath.sv =====
`default_nettype none

module wsms_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire wsms_pkg::wsms_cmd_t              cmd,
    output wsms_pkg::wsms_stat_t                  stat,
    input  wire logic                             cfg_wen,
    input  wire logic [wsms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wsms_pkg::TIME_W-1:0]      cfg_wdata,
    input  wire logic [wsms_pkg::TIME_W-1:0]      in_now,
    input  wire wsms_pkg::wsms_flags_t            in_flags,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [3:0]                            m_mode,
    output logic                                  m_safe_cmd,
    output logic                                  m_swing_cmd,
    output logic                                  m_retract_cmd,
    output logic                                  m_self_right_cmd,
    output logic                                  m_is_nominal,
    output logic                                  m_is_armed
);

    logic [wsms_pkg::TIME_W-1:0] safe_hold_reg;
    logic [wsms_pkg::TIME_W-1:0] self_right_reg;
    logic [wsms_pkg::TIME_W-1:0] now_reg;
    logic [wsms_pkg::TIME_W-1:0] entry_reg;
    wsms_pkg::wsms_flags_t       flags_reg;
    wsms_pkg::mode_t             mode_reg;
    wsms_pkg::mode_t             mode_next;
    logic                        p_safe_reg;
    logic                        p_swing_reg;
    logic                        p_retract_reg;
    logic                        p_sr_reg;
    logic                        m_valid_reg;
    logic [3:0]                  out_mode_reg;
    logic                        out_safe_reg;
    logic                        out_swing_reg;
    logic                        out_retract_reg;
    logic                        out_sr_reg;
    logic                        out_nom_reg;
    logic                        out_armed_reg;
    logic [wsms_pkg::TIME_W-1:0] elapsed;
    logic                        hold_done;
    logic                        sr_done;
    logic                        time_moved;
    logic                        changed;

    assign elapsed    = now_reg - entry_reg;
    assign hold_done  = elapsed > safe_hold_reg;
    assign sr_done    = elapsed > self_right_reg;
    assign time_moved = now_reg != entry_reg;

    always_comb begin
        mode_next = mode_reg;
        case (mode_reg)
            wsms_pkg::MODE_INIT: begin
                mode_next = wsms_pkg::MODE_SAFE;
            end
            wsms_pkg::MODE_SAFE: begin
                if (hold_done && flags_reg.radio_ok) mode_next = wsms_pkg::MODE_UNKNOWN;
            end
            wsms_pkg::MODE_UNKNOWN: begin
                if (!flags_reg.radio_ok) begin
                    mode_next = wsms_pkg::MODE_SAFE;
                end else if (flags_reg.self_right_on) begin
                    if (flags_reg.upright) mode_next = wsms_pkg::MODE_NOMINAL;
                    else if (flags_reg.upside_down) mode_next = wsms_pkg::MODE_NEEDS_SELFRIGHT;
                end else begin
                    mode_next = wsms_pkg::MODE_NOMINAL;
                end
            end
            wsms_pkg::MODE_NOMINAL: begin
                if (!flags_reg.radio_ok) begin
                    mode_next = wsms_pkg::MODE_SAFE;
                end else if (flags_reg.self_right_on) begin
                    if (flags_reg.upside_down) mode_next = wsms_pkg::MODE_NEEDS_SELFRIGHT;
                    else if (!flags_reg.upright) mode_next = wsms_pkg::MODE_UNKNOWN;
                end else if (flags_reg.hammer_ready) begin
                    mode_next = wsms_pkg::MODE_ARMED;
                end
            end
            wsms_pkg::MODE_ARMED: begin
                if (!flags_reg.radio_ok) begin
                    mode_next = wsms_pkg::MODE_SAFE;
                end else if (!flags_reg.hammer_ready) begin
                    mode_next = wsms_pkg::MODE_NOMINAL;
                end else if (flags_reg.self_right_on) begin
                    if (flags_reg.upside_down) mode_next = wsms_pkg::MODE_NEEDS_SELFRIGHT;
                    else if (!flags_reg.upright) mode_next = wsms_pkg::MODE_UNKNOWN;
                end else if (flags_reg.radio_swing || flags_reg.autofire_swing) begin
                    mode_next = wsms_pkg::MODE_SWING_TRIG;
                end else if (flags_reg.retract_request) begin
                    mode_next = wsms_pkg::MODE_RETRACT_TRIG;
                end
            end
            wsms_pkg::MODE_SWING_TRIG, wsms_pkg::MODE_RETRACT_TRIG: begin
                if (time_moved) mode_next = wsms_pkg::MODE_ACTIVE;
            end
            wsms_pkg::MODE_ACTIVE: begin
                if (!flags_reg.radio_ok) mode_next = wsms_pkg::MODE_SAFE;
                else if (flags_reg.hammer_ready || !flags_reg.weapon_enabled)
                    mode_next = wsms_pkg::MODE_UNKNOWN;
            end
            wsms_pkg::MODE_SELFRIGHT_TRIG: begin
                mode_next = wsms_pkg::MODE_ACTIVE;
            end
            wsms_pkg::MODE_NEEDS_SELFRIGHT: begin
                if (!flags_reg.self_right_on || flags_reg.upright)
                    mode_next = wsms_pkg::MODE_NOMINAL;
                else if (!flags_reg.upside_down) mode_next = wsms_pkg::MODE_UNKNOWN;
                else if (sr_done) mode_next = wsms_pkg::MODE_SELFRIGHT_TRIG;
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    assign changed       = mode_next != mode_reg;
    assign stat.changed  = changed;
    assign stat.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            safe_hold_reg  <= wsms_pkg::SAFE_HOLD_RST;
            self_right_reg <= wsms_pkg::SELF_RIGHT_RST;
        end else if (cfg_wen) begin
            if (cfg_index == wsms_pkg::REG_SAFE_HOLD) safe_hold_reg <= cfg_wdata;
            if (cfg_index == wsms_pkg::REG_SELF_RIGHT) self_right_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            now_reg   <= in_now;
            flags_reg <= in_flags;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= wsms_pkg::MODE_INIT;
            entry_reg     <= '0;
            p_safe_reg    <= 1'b0;
            p_swing_reg   <= 1'b0;
            p_retract_reg <= 1'b0;
            p_sr_reg      <= 1'b0;
        end else if (cmd.load_in) begin
            p_safe_reg    <= 1'b0;
            p_swing_reg   <= 1'b0;
            p_retract_reg <= 1'b0;
            p_sr_reg      <= 1'b0;
        end else if (cmd.step && changed) begin
            mode_reg  <= mode_next;
            entry_reg <= now_reg;
            if (mode_next == wsms_pkg::MODE_SAFE) p_safe_reg <= 1'b1;
            if (mode_next == wsms_pkg::MODE_SWING_TRIG) p_swing_reg <= 1'b1;
            if (mode_next == wsms_pkg::MODE_RETRACT_TRIG) p_retract_reg <= 1'b1;
            if (mode_next == wsms_pkg::MODE_SELFRIGHT_TRIG) p_sr_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_mode_reg    <= mode_reg;
            out_safe_reg    <= p_safe_reg;
            out_swing_reg   <= p_swing_reg;
            out_retract_reg <= p_retract_reg;
            out_sr_reg      <= p_sr_reg;
            out_nom_reg     <= (mode_reg == wsms_pkg::MODE_NOMINAL) ||
                               (mode_reg == wsms_pkg::MODE_ARMED);
            out_armed_reg   <= mode_reg == wsms_pkg::MODE_ARMED;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_mode           = out_mode_reg;
    assign m_safe_cmd       = out_safe_reg;
    assign m_swing_cmd      = out_swing_reg;
    assign m_retract_cmd    = out_retract_reg;
    assign m_self_right_cmd = out_sr_reg;
    assign m_is_nominal     = out_nom_reg;
    assign m_is_armed       = out_armed_reg;

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid)
        else $error("result not presented after load");

    a_entry_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && changed) |=> (entry_reg == now_reg))
        else $error("entry time not stamped on transition");

    a_armed_nominal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_armed) |-> m_is_nominal)
        else $error("armed result without nominal flag");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !cmd.load_out)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== rtl/wsms_controller.sv =====
`default_nettype none

module wsms_controller (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire wsms_pkg::wsms_stat_t stat,
    output wsms_pkg::wsms_cmd_t       cmd
);

    wsms_pkg::ctrl_state_t              state_reg;
    wsms_pkg::ctrl_state_t              state_next;
    logic [wsms_pkg::STEP_CNT_W-1:0]    cnt_reg;
    logic [wsms_pkg::STEP_CNT_W-1:0]    cnt_next;
    logic                               last_step;

    assign last_step = cnt_reg == wsms_pkg::STEP_CNT_W'(wsms_pkg::STEP_LIMIT - 1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wsms_pkg::ST_IDLE: begin
                if (s_valid) state_next = wsms_pkg::ST_STEP;
            end
            wsms_pkg::ST_STEP: begin
                if (!stat.changed || last_step) state_next = wsms_pkg::ST_OUT;
            end
            wsms_pkg::ST_OUT: begin
                if (stat.out_free) state_next = wsms_pkg::ST_IDLE;
            end
            default: begin
                state_next = wsms_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        cnt_next     = cnt_reg;
        case (state_reg)
            wsms_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
                cnt_next    = '0;
            end
            wsms_pkg::ST_STEP: begin
                cmd.step = 1'b1;
                if (stat.changed) cnt_next = cnt_reg + 1'b1;
            end
            wsms_pkg::ST_OUT: begin
                cmd.load_out = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wsms_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wsms_pkg::ST_STEP && last_step) |=> (state_reg != wsms_pkg::ST_STEP))
        else $error("settle loop ran past its limit");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> (state_reg == wsms_pkg::ST_STEP && cnt_reg == '0))
        else $error("accepted transaction did not start settling");

endmodule

`default_nettype wire

// ===== rtl/weapon_safety_mode_sequencer.sv =====
// Weapon safety mode sequencer.
// Input channel (s_valid/s_ready): one transaction per control tick carrying
// the microsecond timestamp and the status flags. Result channel
// (m_valid/m_ready): one transaction per tick with the settled mode and the
// command pulses for modes entered during that tick.
// Configuration: cfg_wen writes cfg_wdata into register cfg_index
// (0 safe hold time, 1 self-right delay) at the clock edge; write only idle.
// Processing: the tick is captured at acceptance, then one step per mode
// transition plus one settling check (at most 8 transitions, no check after
// the eighth), then the result is loaded into the output register once the
// result channel is free, which a stalled receiver can delay.
// Throughput: one tick at a time; the next tick is taken in the cycle after
// the result is loaded.
// Reset (aresetn low, synchronous): mode returns to init, entry time to zero,
// configuration registers and command pulses to their defaults, both channels go idle.
// A stalled receiver holds the result in the output register; the block
// takes the next tick meanwhile and waits before loading its result.
`default_nettype none

module weapon_safety_mode_sequencer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wen,
    input  wire logic [wsms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wsms_pkg::TIME_W-1:0]     cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [wsms_pkg::TIME_W-1:0]     s_now_us,
    input  wire logic                            s_radio_ok,
    input  wire logic                            s_self_right_on,
    input  wire logic                            s_upright,
    input  wire logic                            s_upside_down,
    input  wire logic                            s_hammer_ready,
    input  wire logic                            s_radio_swing,
    input  wire logic                            s_autofire_swing,
    input  wire logic                            s_retract_request,
    input  wire logic                            s_weapon_enabled,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [3:0]                           m_mode,
    output logic                                 m_safe_cmd,
    output logic                                 m_swing_cmd,
    output logic                                 m_retract_cmd,
    output logic                                 m_self_right_cmd,
    output logic                                 m_is_nominal,
    output logic                                 m_is_armed
);

    wsms_pkg::wsms_cmd_t   cmd;
    wsms_pkg::wsms_stat_t  stat;
    wsms_pkg::wsms_flags_t flags;

    assign flags.radio_ok        = s_radio_ok;
    assign flags.self_right_on   = s_self_right_on;
    assign flags.upright         = s_upright;
    assign flags.upside_down     = s_upside_down;
    assign flags.hammer_ready    = s_hammer_ready;
    assign flags.radio_swing     = s_radio_swing;
    assign flags.autofire_swing  = s_autofire_swing;
    assign flags.retract_request = s_retract_request;
    assign flags.weapon_enabled  = s_weapon_enabled;

    wsms_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    wsms_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_wen          (cfg_wen),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_now           (s_now_us),
        .in_flags         (flags),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mode           (m_mode),
        .m_safe_cmd       (m_safe_cmd),
        .m_swing_cmd      (m_swing_cmd),
        .m_retract_cmd    (m_retract_cmd),
        .m_self_right_cmd (m_self_right_cmd),
        .m_is_nominal     (m_is_nominal),
        .m_is_armed       (m_is_armed)
    );

endmodule

`default_nettype wire

// ===== bench/weapon_safety_mode_sequencer_test.sv =====
`timescale 1ns / 1ps

module weapon_safety_mode_sequencer_test;

    localparam int unsigned SETTLE_MAX   = 8;
    localparam int unsigned PHASE_TICKS  = 275;
    localparam int unsigned LATENCY_WAIT = 12;

    localparam logic [8:0] F_RADIO   = 9'h100;
    localparam logic [8:0] F_SR_ON   = 9'h080;
    localparam logic [8:0] F_UP      = 9'h040;
    localparam logic [8:0] F_DOWN    = 9'h020;
    localparam logic [8:0] F_READY   = 9'h010;
    localparam logic [8:0] F_SWING   = 9'h008;
    localparam logic [8:0] F_AUTO    = 9'h004;
    localparam logic [8:0] F_RETRACT = 9'h002;
    localparam logic [8:0] F_WEAPON  = 9'h001;

    typedef struct packed {
        logic [3:0] mode;
        logic       safe_cmd;
        logic       swing_cmd;
        logic       retract_cmd;
        logic       self_right_cmd;
        logic       is_nominal;
        logic       is_armed;
    } tick_result_t;

    typedef struct packed {
        logic [31:0]  now;
        logic [8:0]   flags;
        logic         typed;
        tick_result_t want;
    } stim_row_t;

    localparam tick_result_t NO_WANT      = '0;
    localparam tick_result_t SAFE_ENTERED = {wsms_pkg::MODE_SAFE, 6'b10_0000};
    localparam tick_result_t SAFE_HELD    = {wsms_pkg::MODE_SAFE, 6'b00_0000};

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wen = 1'b0;
    logic [wsms_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [wsms_pkg::TIME_W-1:0]    cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [wsms_pkg::TIME_W-1:0]    s_now_us = '0;
    logic                           s_radio_ok = 1'b0;
    logic                           s_self_right_on = 1'b0;
    logic                           s_upright = 1'b0;
    logic                           s_upside_down = 1'b0;
    logic                           s_hammer_ready = 1'b0;
    logic                           s_radio_swing = 1'b0;
    logic                           s_autofire_swing = 1'b0;
    logic                           s_retract_request = 1'b0;
    logic                           s_weapon_enabled = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [3:0]                     m_mode;
    logic                           m_safe_cmd;
    logic                           m_swing_cmd;
    logic                           m_retract_cmd;
    logic                           m_self_right_cmd;
    logic                           m_is_nominal;
    logic                           m_is_armed;

    wsms_pkg::mode_t cur_mode = wsms_pkg::MODE_INIT;
    logic [31:0]     entry_us = '0;
    logic [31:0]     hold_us = wsms_pkg::SAFE_HOLD_RST;
    logic [31:0]     sr_delay_us = wsms_pkg::SELF_RIGHT_RST;

    tick_result_t pending_results[$];
    int           errors = 0;
    int           ticks_sent = 0;
    int           results_seen = 0;
    int           reg_settings = 0;
    int           n_safe = 0;
    int           n_swing = 0;
    int           n_retract = 0;
    int           n_self_right = 0;
    bit [15:0]    modes_seen = '0;
    bit           steady = 1'b0;

    weapon_safety_mode_sequencer uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wen           (cfg_wen),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_now_us          (s_now_us),
        .s_radio_ok        (s_radio_ok),
        .s_self_right_on   (s_self_right_on),
        .s_upright         (s_upright),
        .s_upside_down     (s_upside_down),
        .s_hammer_ready    (s_hammer_ready),
        .s_radio_swing     (s_radio_swing),
        .s_autofire_swing  (s_autofire_swing),
        .s_retract_request (s_retract_request),
        .s_weapon_enabled  (s_weapon_enabled),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_mode            (m_mode),
        .m_safe_cmd        (m_safe_cmd),
        .m_swing_cmd       (m_swing_cmd),
        .m_retract_cmd     (m_retract_cmd),
        .m_self_right_cmd  (m_self_right_cmd),
        .m_is_nominal      (m_is_nominal),
        .m_is_armed        (m_is_armed)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic wsms_pkg::mode_t next_mode_of(wsms_pkg::mode_t m, logic [31:0] now,
                                                     wsms_pkg::wsms_flags_t f);
        logic [31:0] elapsed;
        elapsed = now - entry_us;
        case (m)
            wsms_pkg::MODE_INIT: begin
                return wsms_pkg::MODE_SAFE;
            end
            wsms_pkg::MODE_SAFE: begin
                if (elapsed > hold_us && f.radio_ok) return wsms_pkg::MODE_UNKNOWN;
                return m;
            end
            wsms_pkg::MODE_UNKNOWN: begin
                if (!f.radio_ok) return wsms_pkg::MODE_SAFE;
                if (f.self_right_on) begin
                    if (f.upright) return wsms_pkg::MODE_NOMINAL;
                    if (f.upside_down) return wsms_pkg::MODE_NEEDS_SELFRIGHT;
                    return m;
                end
                return wsms_pkg::MODE_NOMINAL;
            end
            wsms_pkg::MODE_NOMINAL: begin
                if (!f.radio_ok) return wsms_pkg::MODE_SAFE;
                if (f.self_right_on) begin
                    if (f.upside_down) return wsms_pkg::MODE_NEEDS_SELFRIGHT;
                    if (!f.upright) return wsms_pkg::MODE_UNKNOWN;
                    return m;
                end
                if (f.hammer_ready) return wsms_pkg::MODE_ARMED;
                return m;
            end
            wsms_pkg::MODE_ARMED: begin
                if (!f.radio_ok) return wsms_pkg::MODE_SAFE;
                if (!f.hammer_ready) return wsms_pkg::MODE_NOMINAL;
                if (f.self_right_on) begin
                    if (f.upside_down) return wsms_pkg::MODE_NEEDS_SELFRIGHT;
                    if (!f.upright) return wsms_pkg::MODE_UNKNOWN;
                    return m;
                end
                if (f.radio_swing || f.autofire_swing) return wsms_pkg::MODE_SWING_TRIG;
                if (f.retract_request) return wsms_pkg::MODE_RETRACT_TRIG;
                return m;
            end
            wsms_pkg::MODE_SWING_TRIG, wsms_pkg::MODE_RETRACT_TRIG: begin
                if (now != entry_us) return wsms_pkg::MODE_ACTIVE;
                return m;
            end
            wsms_pkg::MODE_ACTIVE: begin
                if (!f.radio_ok) return wsms_pkg::MODE_SAFE;
                if (f.hammer_ready || !f.weapon_enabled) return wsms_pkg::MODE_UNKNOWN;
                return m;
            end
            wsms_pkg::MODE_SELFRIGHT_TRIG: begin
                return wsms_pkg::MODE_ACTIVE;
            end
            wsms_pkg::MODE_NEEDS_SELFRIGHT: begin
                if (!f.self_right_on || f.upright) return wsms_pkg::MODE_NOMINAL;
                if (!f.upside_down) return wsms_pkg::MODE_UNKNOWN;
                if (elapsed > sr_delay_us) return wsms_pkg::MODE_SELFRIGHT_TRIG;
                return m;
            end
            default: begin
                return m;
            end
        endcase
    endfunction

    function automatic tick_result_t settle_tick(logic [31:0] now, wsms_pkg::wsms_flags_t f);
        tick_result_t    r;
        wsms_pkg::mode_t nx;
        int              n;
        r = '0;
        for (n = 0; n < SETTLE_MAX; n++) begin
            nx = next_mode_of(cur_mode, now, f);
            if (nx == cur_mode) break;
            cur_mode = nx;
            entry_us = now;
            if (nx == wsms_pkg::MODE_SAFE) r.safe_cmd = 1'b1;
            if (nx == wsms_pkg::MODE_SWING_TRIG) r.swing_cmd = 1'b1;
            if (nx == wsms_pkg::MODE_RETRACT_TRIG) r.retract_cmd = 1'b1;
            if (nx == wsms_pkg::MODE_SELFRIGHT_TRIG) r.self_right_cmd = 1'b1;
        end
        r.mode = cur_mode;
        r.is_nominal = (cur_mode == wsms_pkg::MODE_NOMINAL || cur_mode == wsms_pkg::MODE_ARMED);
        r.is_armed = (cur_mode == wsms_pkg::MODE_ARMED);
        return r;
    endfunction

    task automatic write_reg(input logic [wsms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_wen = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wen = 1'b0;
        if (idx == wsms_pkg::REG_SAFE_HOLD) begin
            hold_us = val;
        end else begin
            sr_delay_us = val;
        end
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (LATENCY_WAIT) @(negedge aclk);
    endtask

    task automatic send_tick(input logic [31:0] now, input wsms_pkg::wsms_flags_t f,
                             input logic typed, input tick_result_t want);
        int           gap;
        tick_result_t r;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_now_us = now;
        {s_radio_ok, s_self_right_on, s_upright, s_upside_down, s_hammer_ready,
         s_radio_swing, s_autofire_swing, s_retract_request, s_weapon_enabled} = f;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = settle_tick(now, f);
        pending_results.push_back(typed ? want : r);
        ticks_sent++;
        modes_seen[r.mode] = 1'b1;
        n_safe += int'(r.safe_cmd);
        n_swing += int'(r.swing_cmd);
        n_retract += int'(r.retract_cmd);
        n_self_right += int'(r.self_right_cmd);
        @(negedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    initial begin
        tick_result_t want;
        int           stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("mode: unexpected transaction, expected none, got %0d", m_mode);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("mode", 32'(want.mode), 32'(m_mode));
                check_field("safe_cmd", 32'(want.safe_cmd), 32'(m_safe_cmd));
                check_field("swing_cmd", 32'(want.swing_cmd), 32'(m_swing_cmd));
                check_field("retract_cmd", 32'(want.retract_cmd), 32'(m_retract_cmd));
                check_field("self_right_cmd", 32'(want.self_right_cmd),
                            32'(m_self_right_cmd));
                check_field("is_nominal", 32'(want.is_nominal), 32'(m_is_nominal));
                check_field("is_armed", 32'(want.is_armed), 32'(m_is_armed));
            end
            @(negedge aclk);
        end
    end

    initial begin
        stim_row_t             rows [0:23];
        wsms_pkg::wsms_flags_t flg;
        logic [31:0]           now;
        logic [31:0]           hold;
        logic [31:0]           dly;
        int                    span;
        int                    pick;
        int                    orient;
        int                    i;
        int                    p;
        int                    k;

        rows = '{
            '{32'd0,          9'h000,                               1'b1, SAFE_ENTERED},
            '{32'd1000000,    F_RADIO,                              1'b1, SAFE_HELD},
            '{32'd1000001,    F_RADIO,                              1'b0, NO_WANT},
            '{32'd1000002,    F_RADIO | F_READY,                    1'b0, NO_WANT},
            '{32'd1000003,    F_RADIO | F_READY | F_SWING,          1'b0, NO_WANT},
            '{32'd1000003,    F_RADIO | F_READY | F_SWING,          1'b0, NO_WANT},
            '{32'd1000004,    F_RADIO | F_WEAPON,                   1'b0, NO_WANT},
            '{32'd1000005,    F_RADIO | F_READY,                    1'b0, NO_WANT},
            '{32'd1000006,    F_RADIO | F_READY | F_AUTO,           1'b0, NO_WANT},
            '{32'd1000007,    F_RADIO | F_READY,                    1'b0, NO_WANT},
            '{32'd1000008,    F_RADIO | F_READY | F_RETRACT,        1'b0, NO_WANT},
            '{32'd1000009,    F_RADIO,                              1'b0, NO_WANT},
            '{32'd1000010,    F_RADIO | F_SR_ON | F_DOWN,           1'b0, NO_WANT},
            '{32'd3000010,    F_RADIO | F_SR_ON | F_DOWN,           1'b0, NO_WANT},
            '{32'd3000011,    F_RADIO | F_SR_ON | F_DOWN | F_WEAPON, 1'b0, NO_WANT},
            '{32'd3000012,    F_WEAPON,                             1'b1, SAFE_ENTERED},
            '{32'd4000013,    F_RADIO | F_SR_ON,                    1'b0, NO_WANT},
            '{32'd4000014,    F_SR_ON | F_UP,                       1'b1, SAFE_ENTERED},
            '{32'd5000015,    F_RADIO | F_SR_ON | F_UP | F_DOWN,    1'b0, NO_WANT},
            '{32'hFFFF_FF00,  F_RADIO | F_SR_ON | F_DOWN,           1'b0, NO_WANT},
            '{32'd1999744,    F_RADIO | F_SR_ON | F_DOWN,           1'b0, NO_WANT},
            '{32'd1999745,    F_RADIO | F_SR_ON | F_DOWN | F_READY, 1'b0, NO_WANT},
            '{32'hFFFF_FFFF,  9'h1FF,                               1'b0, NO_WANT},
            '{32'h0000_0000,  9'h000,                               1'b0, NO_WANT}
        };

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (i = 0; i < 24; i++) begin
            send_tick(rows[i].now, rows[i].flags, rows[i].typed, rows[i].want);
        end
        s_valid = 1'b0;
        wait_idle();

        for (p = 0; p < 6; p++) begin
            now = $urandom;
            case (p)
                0: begin
                    hold = 32'd0;
                    dly = 32'd0;
                    span = 60;
                    now = 32'hFFFF_F000;
                end
                1: begin
                    hold = 32'hFFFF_FFFF;
                    dly = 32'hFFFF_FFFF;
                    span = 5000;
                end
                2: begin
                    hold = $urandom_range(1, 200);
                    dly = $urandom_range(1, 200);
                    span = 150;
                end
                3: begin
                    hold = 32'd0;
                    dly = 32'hFFFF_FFFF;
                    span = 100;
                end
                4: begin
                    hold = wsms_pkg::SAFE_HOLD_RST;
                    dly = wsms_pkg::SELF_RIGHT_RST;
                    span = 700000;
                end
                default: begin
                    hold = $urandom_range(0, 40);
                    dly = $urandom_range(0, 40);
                    span = 40;
                end
            endcase
            write_reg(wsms_pkg::REG_SAFE_HOLD, hold);
            write_reg(wsms_pkg::REG_SELF_RIGHT, dly);
            reg_settings++;

            for (k = 0; k < PHASE_TICKS; k++) begin
                if (k % 40 == 0) steady = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    now = $urandom;
                end else if (pick < 8) begin
                    now += $urandom_range(0, 3000000);
                end else begin
                    now += $urandom_range(0, span);
                end
                if ($urandom_range(0, 9) == 0) begin
                    flg = 9'($urandom);
                end else begin
                    orient = $urandom_range(0, 9);
                    flg.radio_ok = ($urandom_range(0, 19) != 0);
                    flg.self_right_on = 1'($urandom_range(0, 1));
                    flg.upright = (orient < 5 || orient == 9);
                    flg.upside_down = (orient >= 5);
                    flg.hammer_ready = 1'($urandom_range(0, 1));
                    flg.radio_swing = ($urandom_range(0, 4) == 0);
                    flg.autofire_swing = ($urandom_range(0, 6) == 0);
                    flg.retract_request = ($urandom_range(0, 4) == 0);
                    flg.weapon_enabled = ($urandom_range(0, 4) != 0);
                    if (orient == 8) flg.upside_down = 1'b0;
                end
                send_tick(now, flg, 1'b0, NO_WANT);
            end
            s_valid = 1'b0;
            steady = 1'b0;
            wait_idle();
        end

        repeat (20) @(negedge aclk);
        $display("run: %0d ticks sent, %0d results checked, %0d register settings",
                 ticks_sent, results_seen, reg_settings);
        $display("run: %0d modes reached; pulses safe %0d swing %0d retract %0d self-right %0d",
                 $countones(modes_seen), n_safe, n_swing, n_retract, n_self_right);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
